/* rtl/iqbq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IQ biquad package
// Shared widths, payload structs, command struct and codes for the IQ
// direct-form-II biquad filter core.
// ----------------------------------------------------------------------------
package iqbq_pkg;

  // Field widths.
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;
  localparam int STATE_WIDTH  = 32;

  // Fraction bits of each format.
  localparam int XFRAC = SAMPLE_WIDTH - 1;
  localparam int CFRAC = COEF_WIDTH - 2;
  localparam int SFRAC = STATE_WIDTH / 2;

  // Alignment between the sample format and the product format.
  localparam int X_SHIFT   = SFRAC + CFRAC - XFRAC;

  // Product and accumulator widths; three guard bits cover a three-term sum.
  localparam int PROD_WIDTH = COEF_WIDTH + STATE_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 3;

  // Configuration register file.
  localparam int NUM_COEF      = 5;
  localparam int CFG_IDX_WIDTH = $clog2(NUM_COEF);

  // Microcode steps for one lane.
  localparam int STEPS_PER_LANE = 9;
  localparam int STEP_WIDTH     = $clog2(STEPS_PER_LANE);

  // Register indexes, also used to select the multiplier coefficient.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    COEF_A1 = 3'd0,
    COEF_A2 = 3'd1,
    COEF_B0 = 3'd2,
    COEF_B1 = 3'd3,
    COEF_B2 = 3'd4
  } coef_idx_e;

  // State word fed to the multiplier.
  typedef enum logic [1:0] {
    OPND_W1,
    OPND_W2,
    OPND_W0
  } opnd_sel_e;

  // Accumulator operation.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_LOAD_PROD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  // Sequencer steps for one lane.
  typedef enum logic [STEP_WIDTH-1:0] {
    STEP_MUL_A1,
    STEP_MUL_A2,
    STEP_ACC_A2,
    STEP_ROUND_W0,
    STEP_MUL_B0,
    STEP_MUL_B1,
    STEP_MUL_B2,
    STEP_ACC_B2,
    STEP_ROUND_Y
  } step_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUBLISH
  } state_e;

  // Input transaction payload.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] in_i;
    logic signed [SAMPLE_WIDTH-1:0] in_q;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_i;
    logic signed [SAMPLE_WIDTH-1:0] out_q;
  } out_item_t;

  // Configuration write payload.
  typedef struct packed {
    logic [CFG_IDX_WIDTH-1:0]     index;
    logic signed [COEF_WIDTH-1:0] value;
  } cfg_write_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      lane;
    logic      mul_en;
    coef_idx_e coef_sel;
    opnd_sel_e opnd_sel;
    acc_op_e   acc_op;
    logic      w0_en;
    logic      res_en;
    logic      publish;
  } dp_cmd_t;

endpackage

/* rtl/iqbq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IQ biquad controller
// Sequences the shared multiply-accumulate through nine steps per lane and
// manages the input and output handshakes.
// ----------------------------------------------------------------------------
module iqbq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output iqbq_pkg::dp_cmd_t cmd_o
);
  import iqbq_pkg::*;

  state_e  state_q, state_d;
  step_e   step_q, step_d;
  logic    lane_q, lane_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;

  // Microcode for one step of one lane.
  function automatic dp_cmd_t ucode(input step_e step, input logic lane);
    dp_cmd_t c;
    c          = '0;
    c.lane     = lane;
    c.coef_sel = COEF_A1;
    c.opnd_sel = OPND_W1;
    c.acc_op   = ACC_HOLD;
    case (step)
      STEP_MUL_A1: begin
        c.mul_en   = 1'b1;
        c.coef_sel = COEF_A1;
        c.opnd_sel = OPND_W1;
        c.acc_op   = ACC_LOAD_X;
      end
      STEP_MUL_A2: begin
        c.mul_en   = 1'b1;
        c.coef_sel = COEF_A2;
        c.opnd_sel = OPND_W2;
        c.acc_op   = ACC_SUB;
      end
      STEP_ACC_A2: begin
        c.acc_op = ACC_ADD;
      end
      STEP_ROUND_W0: begin
        c.w0_en = 1'b1;
      end
      STEP_MUL_B0: begin
        c.mul_en   = 1'b1;
        c.coef_sel = COEF_B0;
        c.opnd_sel = OPND_W0;
      end
      STEP_MUL_B1: begin
        c.mul_en   = 1'b1;
        c.coef_sel = COEF_B1;
        c.opnd_sel = OPND_W1;
        c.acc_op   = ACC_LOAD_PROD;
      end
      STEP_MUL_B2: begin
        c.mul_en   = 1'b1;
        c.coef_sel = COEF_B2;
        c.opnd_sel = OPND_W2;
        c.acc_op   = ACC_ADD;
      end
      STEP_ACC_B2: begin
        c.acc_op = ACC_ADD;
      end
      STEP_ROUND_Y: begin
        c.res_en = 1'b1;
      end
      default: begin
        c.acc_op = ACC_HOLD;
      end
    endcase
    return c;
  endfunction

  // State, step and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_MUL_A1;
      lane_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    lane_d     = lane_q;
    in_ready_o = 1'b0;
    cmd        = ucode(STEP_MUL_A1, 1'b0);
    cmd.mul_en = 1'b0;
    cmd.acc_op = ACC_HOLD;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          step_d      = STEP_MUL_A1;
          lane_d      = 1'b0;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd = ucode(step_q, lane_q);
        if (step_q == STEP_ROUND_Y) begin
          step_d = STEP_MUL_A1;
          if (lane_q) begin
            state_d = ST_PUBLISH;
          end else begin
            lane_d = 1'b1;
          end
        end else begin
          step_d = step_e'(step_q + 1'b1);
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.publish = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The output register holds a result until its transaction completes.
  always_comb begin
    if (cmd.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* rtl/iqbq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IQ biquad datapath
// Coefficient registers, per-lane delay words, one shared multiplier with a
// registered product, the accumulator and the rounding and saturation logic.
// ----------------------------------------------------------------------------
module iqbq_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iqbq_pkg::dp_cmd_t    cmd_i,
  input  iqbq_pkg::in_item_t   in_data_i,
  input  logic                 cfg_we_i,
  input  iqbq_pkg::cfg_write_t cfg_data_i,
  output iqbq_pkg::out_item_t  out_data_o
);
  import iqbq_pkg::*;

  // Kept signed so that the rounding sums below shift arithmetically.
  localparam logic signed [ACC_WIDTH-1:0] W0_RND  = ACC_WIDTH'(1) << (CFRAC - 1);
  localparam logic signed [ACC_WIDTH-1:0] OUT_RND = ACC_WIDTH'(1) << (X_SHIFT - 1);

  logic signed [COEF_WIDTH-1:0]   coef_a1_q, coef_a2_q, coef_b0_q, coef_b1_q, coef_b2_q;
  logic signed [STATE_WIDTH-1:0]  w1_q [2];
  logic signed [STATE_WIDTH-1:0]  w2_q [2];
  logic signed [SAMPLE_WIDTH-1:0] x_q [2];
  logic signed [SAMPLE_WIDTH-1:0] res_q [2];
  logic signed [STATE_WIDTH-1:0]  w0_q, w0_d;
  logic signed [SAMPLE_WIDTH-1:0] y_d;
  logic signed [PROD_WIDTH-1:0]   prod_q, prod_d;
  logic signed [ACC_WIDTH-1:0]    acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0]    acc_x, acc_prod, w0_shift, y_shift;
  logic signed [COEF_WIDTH-1:0]   coef_op;
  logic signed [STATE_WIDTH-1:0]  opnd;
  logic signed [SAMPLE_WIDTH-1:0] x_lane;
  out_item_t                      out_q;

  // Saturate a sign-extended value to the state width.
  function automatic logic [STATE_WIDTH-1:0] sat_state(input logic [ACC_WIDTH-1:0] v);
    logic [ACC_WIDTH-STATE_WIDTH:0] upper;
    upper = v[ACC_WIDTH-1:STATE_WIDTH-1];
    if (&upper || ~|upper) begin
      return v[STATE_WIDTH-1:0];
    end else if (v[ACC_WIDTH-1]) begin
      return {1'b1, {(STATE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end
  endfunction

  // Saturate a sign-extended value to the sample width.
  function automatic logic [SAMPLE_WIDTH-1:0] sat_sample(input logic [ACC_WIDTH-1:0] v);
    logic [ACC_WIDTH-SAMPLE_WIDTH:0] upper;
    upper = v[ACC_WIDTH-1:SAMPLE_WIDTH-1];
    if (&upper || ~|upper) begin
      return v[SAMPLE_WIDTH-1:0];
    end else if (v[ACC_WIDTH-1]) begin
      return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  endfunction

  // Multiplier operand selection.
  always_comb begin
    case (cmd_i.coef_sel)
      COEF_A1: coef_op = coef_a1_q;
      COEF_A2: coef_op = coef_a2_q;
      COEF_B0: coef_op = coef_b0_q;
      COEF_B1: coef_op = coef_b1_q;
      COEF_B2: coef_op = coef_b2_q;
      default: coef_op = coef_a1_q;
    endcase
    case (cmd_i.opnd_sel)
      OPND_W1: opnd = w1_q[cmd_i.lane];
      OPND_W2: opnd = w2_q[cmd_i.lane];
      OPND_W0: opnd = w0_q;
      default: opnd = w1_q[cmd_i.lane];
    endcase
  end

  assign prod_d = coef_op * opnd;

  // Sample and product aligned to the accumulator.
  assign x_lane   = x_q[cmd_i.lane];
  assign acc_x    = {{(ACC_WIDTH-SAMPLE_WIDTH-X_SHIFT){x_lane[SAMPLE_WIDTH-1]}},
                     x_lane, {X_SHIFT{1'b0}}};
  assign acc_prod = {{(ACC_WIDTH-PROD_WIDTH){prod_q[PROD_WIDTH-1]}}, prod_q};

  // Accumulator update.
  always_comb begin
    case (cmd_i.acc_op)
      ACC_HOLD:      acc_d = acc_q;
      ACC_LOAD_X:    acc_d = acc_x;
      ACC_LOAD_PROD: acc_d = acc_prod;
      ACC_ADD:       acc_d = acc_q + acc_prod;
      ACC_SUB:       acc_d = acc_q - acc_prod;
      default:       acc_d = acc_q;
    endcase
  end

  // Round half up, then saturate, for the new delay word and the output.
  assign w0_shift = (acc_q + W0_RND) >>> CFRAC;
  assign y_shift  = (acc_q + OUT_RND) >>> X_SHIFT;
  assign w0_d     = sat_state(w0_shift);
  assign y_d      = sat_sample(y_shift);

  // Coefficient registers and delay words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a1_q <= '0;
      coef_a2_q <= '0;
      coef_b0_q <= '0;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      w1_q[0]   <= '0;
      w1_q[1]   <= '0;
      w2_q[0]   <= '0;
      w2_q[1]   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_data_i.index)
          COEF_A1: coef_a1_q <= cfg_data_i.value;
          COEF_A2: coef_a2_q <= cfg_data_i.value;
          COEF_B0: coef_b0_q <= cfg_data_i.value;
          COEF_B1: coef_b1_q <= cfg_data_i.value;
          COEF_B2: coef_b2_q <= cfg_data_i.value;
          default: coef_a1_q <= coef_a1_q;
        endcase
      end
      if (cmd_i.res_en) begin
        w2_q[cmd_i.lane] <= w1_q[cmd_i.lane];
        w1_q[cmd_i.lane] <= w0_q;
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q[0] <= in_data_i.in_i;
      x_q[1] <= in_data_i.in_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
    if (cmd_i.w0_en) begin
      w0_q <= w0_d;
    end
    if (cmd_i.res_en) begin
      res_q[cmd_i.lane] <= y_d;
    end
    if (cmd_i.publish) begin
      out_q.out_i <= res_q[0];
      out_q.out_q <= res_q[1];
    end
  end

  assign out_data_o = out_q;

endmodule

/* rtl/iq_biquad_iir_filter_core.sv */
`timescale 1ns / 1ps
// An accepted sample runs through ST_RUN for the I lane, then the Q lane, and then
// ST_PUBLISH raises out_valid_o. A new sample is taken only after that, since the
// single shared multiplier runs nine sequencer steps for each of the two lanes.
// A finished result waits in the output register while the next item is taken.
// Reset clears all coefficients and delay words to zero and empties the output.
// ----------------------------------------------------------------------------
// IQ biquad IIR filter core
// One direct-form-II second-order section applied to the I and Q lanes with
// shared coefficients and separate delay words.
// ----------------------------------------------------------------------------
module iq_biquad_iir_filter_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  iqbq_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output iqbq_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  iqbq_pkg::cfg_write_t cfg_data_i
);
  import iqbq_pkg::*;

  dp_cmd_t cmd;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  iqbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  iqbq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

/* rtl/iqbq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IQ biquad checker
// Port-level assertions on the filter core, attached by a bind statement.
// ----------------------------------------------------------------------------
module iqbq_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input iqbq_pkg::in_item_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input iqbq_pkg::out_item_t  out_data_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input iqbq_pkg::cfg_write_t cfg_data_i
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or was dropped");

  // After an input transaction the core is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a sample is still being filtered");

  // A new result appears only at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a sample in progress");

  // A busy core with a stalled result stays busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !in_ready_o |=> !in_ready_o)
    else $error("core freed while its result could not be delivered");

endmodule

bind iq_biquad_iir_filter_core iqbq_checker u_iqbq_checker (.*);
